// File: rtl/core/lirm_pkg.sv
`timescale 1ns / 1ps
// Shared widths, codes and reset values of the linear interpolation resample mixer.
package lirm_pkg;

   localparam int unsigned SampleWidth  = 16;
   localparam int unsigned IndexWidth   = 12;
   localparam int unsigned RatioWidth   = 20;
   localparam int unsigned GainWidth    = 16;
   localparam int unsigned LengthWidth  = 13;
   localparam int unsigned CsrIndexWidth = 2;
   localparam int unsigned CsrDataWidth  = 20;

   // Read position k * ratio in Q.16 and the extended length/address domain.
   localparam int unsigned PosWidth     = 32;
   localparam int unsigned FracWidth    = 16;
   localparam int unsigned LenWidth     = 17;

   localparam int unsigned DefaultBufferDepth = 4096;

   localparam logic [RatioWidth-1:0]  RatioReset  = 20'd65536;
   localparam logic [GainWidth-1:0]   GainReset   = 16'd4096;
   localparam logic [LengthWidth-1:0] LengthReset = 13'd4096;

   localparam int SampleMax = 32767;
   localparam int SampleMin = -32768;

   typedef enum logic {
      CmdStore   = 1'b0,
      CmdCompute = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      StatusStored = 2'd0,
      StatusValid  = 2'd1,
      StatusRange  = 2'd2
   } status_type;

   typedef enum logic [CsrIndexWidth-1:0] {
      CsrRateRatio    = 2'd0,
      CsrVolumeGain   = 2'd1,
      CsrBufferLength = 2'd2
   } csr_reg_type;

endpackage

// File: rtl/core/lirm_if.sv
`timescale 1ns / 1ps
// Request and response channel interfaces of the resample mixer.
interface lirm_req_if;
   import lirm_pkg::*;

   logic                          valid;
   logic                          ready;
   cmd_type                       cmd;
   logic [IndexWidth-1:0]         index;
   logic signed [SampleWidth-1:0] sample_value;
   logic signed [SampleWidth-1:0] mix_value;

   modport source (output valid, cmd, index, sample_value, mix_value, input ready);
   modport sink   (input valid, cmd, index, sample_value, mix_value, output ready);
endinterface

interface lirm_rsp_if;
   import lirm_pkg::*;

   logic                          valid;
   logic                          ready;
   status_type                    status;
   logic signed [SampleWidth-1:0] result_sample;

   modport source (output valid, status, result_sample, input ready);
   modport sink   (input valid, status, result_sample, output ready);
endinterface

// File: rtl/core/lirm_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM with one write port and a registered read port.
module lirm_ram #(
   parameter int unsigned WIDTH = 16,
   parameter int unsigned DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/linear_interp_resample_mixer.sv
`timescale 1ns / 1ps
// Top level of the linear interpolation resample mixer.
//
// The block holds a buffer of signed 16-bit samples in one synchronous RAM.
// A request transaction with cmd set to store writes sample_value at index
// and answers with status 0. A compute transaction names output index k and
// brings mix_value; the block reads the two buffer samples around position
// k * rate_ratio, scales both by volume_gain, interpolates by the fraction
// and returns mix_value plus that value, saturated, with status 1. An index
// at or beyond round(buffer_length / rate_ratio) answers status 2 and zero.
// Every request transaction yields exactly one response transaction.
//
// One item is in flight at a time. A store goes straight to the done state,
// an out-of-range compute after the multiply and address states, and a full
// compute adds the two reads of the single RAM port and the volume, scale,
// interpolation and mix steps. The next request is accepted in the cycle
// after the result moves into the response register, so a waiting response
// does not hold back the following item's work. When the receiver stalls, a
// finished result waits in the core until the response register frees up.
// Reset clears the control state and loads the default ratio 1.0, volume 1.0
// and full buffer length; the buffer contents are undefined until written.
// Configuration must be written only while idle; the block does not check it.
module linear_interp_resample_mixer #(
   parameter int unsigned BUFFER_DEPTH = lirm_pkg::DefaultBufferDepth
) (
   input  logic                                clock,
   input  logic                                reset,
   lirm_req_if.sink                            req_if,
   lirm_rsp_if.source                          rsp_if,
   input  logic                                csr_we,
   input  logic [lirm_pkg::CsrIndexWidth-1:0]  csr_index,
   input  logic [lirm_pkg::CsrDataWidth-1:0]   csr_wdata
);
   import lirm_pkg::*;

   localparam int unsigned AddrWidth   = $clog2(BUFFER_DEPTH);
   localparam int unsigned CheckWidth  = PosWidth + 2;
   localparam int unsigned VolWidth    = SampleWidth + GainWidth + 1;
   localparam int unsigned ScaledWidth = VolWidth - 12;
   localparam int unsigned DiffWidth   = SampleWidth + 1;
   localparam int unsigned IprodWidth  = 2 * DiffWidth;
   localparam int unsigned NumWidth    = IprodWidth + 1;
   localparam logic [LenWidth-1:0] DepthLen = LenWidth'(BUFFER_DEPTH);

   typedef enum logic [8:0] {
      StIdle   = 9'b000000001,
      StMul    = 9'b000000010,
      StAddr   = 9'b000000100,
      StRdHi   = 9'b000001000,
      StVolA   = 9'b000010000,
      StScale  = 9'b000100000,
      StInterp = 9'b001000000,
      StMix    = 9'b010000000,
      StDone   = 9'b100000000
   } state_type;

   // Truncating saturation of a wide signed value to the sample range.
   function automatic logic signed [SampleWidth-1:0] sat_sample(
      input logic signed [ScaledWidth-1:0] v
   );
      logic signed [SampleWidth-1:0] r;
      if (v > ScaledWidth'(SampleMax)) begin
         r = SampleWidth'(SampleMax);
      end else if (v < ScaledWidth'(SampleMin)) begin
         r = SampleWidth'(SampleMin);
      end else begin
         r = v[SampleWidth-1:0];
      end
      return r;
   endfunction

   // Divide the volume product by 4096 toward zero, then saturate.
   function automatic logic signed [SampleWidth-1:0] vol_scale(
      input logic signed [VolWidth-1:0] p
   );
      logic signed [VolWidth-1:0] biased;
      biased = p[VolWidth-1] ? p + VolWidth'(4095) : p;
      return sat_sample(biased[VolWidth-1:12]);
   endfunction

   // Configuration registers.
   logic [RatioWidth-1:0]  ratio_ff, ratio_in;
   logic [GainWidth-1:0]   gain_ff, gain_in;
   logic [LengthWidth-1:0] length_ff, length_in;

   // Control state.
   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // Per-item working registers.
   logic [IndexWidth-1:0]         idx_ff, idx_in;
   logic signed [SampleWidth-1:0] mix_ff, mix_in;
   logic [LenWidth-1:0]           len_ff, len_in;
   logic [PosWidth-1:0]           pos_ff, pos_in;
   logic [FracWidth-1:0]          frac_ff, frac_in;
   logic [AddrWidth-1:0]          hi_addr_ff, hi_addr_in;
   logic signed [VolWidth-1:0]    prod_a_ff, prod_a_in;
   logic signed [VolWidth-1:0]    prod_b_ff, prod_b_in;
   logic signed [SampleWidth-1:0] a_ff, a_in;
   logic signed [SampleWidth-1:0] b_ff, b_in;
   logic signed [IprodWidth-1:0]  iprod_ff, iprod_in;
   status_type                    res_status_ff, res_status_in;
   logic signed [SampleWidth-1:0] res_sample_ff, res_sample_in;
   status_type                    rsp_status_ff, rsp_status_in;
   logic signed [SampleWidth-1:0] rsp_sample_ff, rsp_sample_in;

   // Combinational helpers.
   logic                          req_accept;
   logic                          rsp_load;
   logic [LenWidth-1:0]           len_ext;
   logic [LenWidth-1:0]           len_clamp;
   logic [LenWidth-1:0]           idx_ext;
   logic [CheckWidth-1:0]         pos_check;
   logic [CheckWidth-1:0]         pos_limit;
   logic                          range_err;
   logic [FracWidth-1:0]          frac;
   logic [LenWidth-1:0]           lo_raw, hi_raw, len_m1, lo_clamp, hi_clamp;
   logic signed [SampleWidth-1:0] rd_sample;
   logic signed [GainWidth:0]     gain_s;
   logic signed [VolWidth-1:0]    vol_prod;
   logic signed [DiffWidth-1:0]   diff;
   logic signed [DiffWidth-1:0]   frac_s;
   logic signed [NumWidth-1:0]    num, num_biased;
   logic signed [SampleWidth-1:0] interp;
   logic signed [ScaledWidth-1:0] mixed;

   // Sample buffer RAM.
   logic                   ram_we;
   logic [AddrWidth-1:0]   ram_waddr;
   logic [AddrWidth-1:0]   ram_raddr;
   logic [SampleWidth-1:0] ram_rdata;

   lirm_ram #(
      .WIDTH (SampleWidth),
      .DEPTH (BUFFER_DEPTH)
   ) u_sample_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (req_if.sample_value),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign req_if.ready     = (state_ff == StIdle);
   assign req_accept       = req_if.valid && req_if.ready;
   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.status    = rsp_status_ff;
   assign rsp_if.result_sample = rsp_sample_ff;
   assign rsp_load         = (state_ff == StDone) && (!rsp_valid_ff || rsp_if.ready);

   // A buffer_length of zero acts as one; anything above the depth acts as the depth.
   assign len_ext   = LenWidth'(length_ff);
   assign len_clamp = (len_ext == '0) ? LenWidth'(1) :
                      (len_ext > DepthLen) ? DepthLen : len_ext;
   assign idx_ext   = LenWidth'(req_if.index);

   // Store writes go straight to the RAM at acceptance; addresses past the
   // depth are dropped but still answered.
   assign ram_we    = req_accept && (req_if.cmd == CmdStore) && (idx_ext < DepthLen);
   assign ram_waddr = AddrWidth'(idx_ext);

   // The index is in range iff (2k + 1) * ratio <= 2 * len * 65536, and
   // (2k + 1) * ratio is simply 2 * pos + ratio.
   assign pos_check = {1'b0, pos_ff, 1'b0} + CheckWidth'(ratio_ff);
   assign pos_limit = CheckWidth'({len_ff, {(FracWidth + 1){1'b0}}});
   assign range_err = pos_check > pos_limit;

   // Floor and ceiling neighbors, both clamped to the last valid sample.
   assign frac     = pos_ff[FracWidth-1:0];
   assign lo_raw   = LenWidth'(pos_ff[PosWidth-1:FracWidth]);
   assign hi_raw   = lo_raw + LenWidth'(frac != '0);
   assign len_m1   = len_ff - LenWidth'(1);
   assign lo_clamp = (lo_raw > len_m1) ? len_m1 : lo_raw;
   assign hi_clamp = (hi_raw > len_m1) ? len_m1 : hi_raw;

   // The floor sample is addressed while the position is checked; the
   // ceiling sample in the cycle that follows.
   assign ram_raddr = (state_ff == StAddr) ? AddrWidth'(lo_clamp) : hi_addr_ff;

   // One volume multiplier serves both neighbors as their read data arrives.
   assign rd_sample = ram_rdata;
   assign gain_s    = {1'b0, gain_ff};
   assign vol_prod  = VolWidth'(rd_sample) * VolWidth'(gain_s);

   assign diff   = DiffWidth'(b_ff) - DiffWidth'(a_ff);
   assign frac_s = {1'b0, frac_ff};

   // interp = (a * 65536 + f * (b - a)) / 65536, truncated toward zero.
   // The quotient lies between a and b, so its low sample bits are exact.
   assign num        = NumWidth'($signed({a_ff, {FracWidth{1'b0}}})) + NumWidth'(iprod_ff);
   assign num_biased = num[NumWidth-1] ? num + NumWidth'(65535) : num;
   assign interp     = num_biased[FracWidth+SampleWidth-1:FracWidth];
   assign mixed      = ScaledWidth'(mix_ff) + ScaledWidth'(interp);

   always_comb begin
      ratio_in      = ratio_ff;
      gain_in       = gain_ff;
      length_in     = length_ff;
      state_in      = state_ff;
      idx_in        = idx_ff;
      mix_in        = mix_ff;
      len_in        = len_ff;
      pos_in        = pos_ff;
      frac_in       = frac_ff;
      hi_addr_in    = hi_addr_ff;
      prod_a_in     = prod_a_ff;
      prod_b_in     = prod_b_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      iprod_in      = iprod_ff;
      res_status_in = res_status_ff;
      res_sample_in = res_sample_ff;

      if (csr_we) begin
         case (csr_index)
            CsrRateRatio:    ratio_in  = csr_wdata[RatioWidth-1:0];
            CsrVolumeGain:   gain_in   = csr_wdata[GainWidth-1:0];
            CsrBufferLength: length_in = csr_wdata[LengthWidth-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         StIdle: begin
            if (req_accept) begin
               idx_in = req_if.index;
               mix_in = req_if.mix_value;
               len_in = len_clamp;
               if (req_if.cmd == CmdStore) begin
                  res_status_in = StatusStored;
                  res_sample_in = '0;
                  state_in      = StDone;
               end else begin
                  state_in = StMul;
               end
            end
         end
         StMul: begin
            pos_in   = PosWidth'(idx_ff) * PosWidth'(ratio_ff);
            state_in = StAddr;
         end
         StAddr: begin
            if (range_err) begin
               res_status_in = StatusRange;
               res_sample_in = '0;
               state_in      = StDone;
            end else begin
               frac_in    = frac;
               hi_addr_in = AddrWidth'(hi_clamp);
               state_in   = StRdHi;
            end
         end
         StRdHi: begin
            prod_a_in = vol_prod;
            state_in  = StVolA;
         end
         StVolA: begin
            prod_b_in = vol_prod;
            state_in  = StScale;
         end
         StScale: begin
            a_in     = vol_scale(prod_a_ff);
            b_in     = vol_scale(prod_b_ff);
            state_in = StInterp;
         end
         StInterp: begin
            iprod_in = IprodWidth'(diff) * IprodWidth'(frac_s);
            state_in = StMix;
         end
         StMix: begin
            res_status_in = StatusValid;
            res_sample_in = sat_sample(mixed);
            state_in      = StDone;
         end
         StDone: begin
            if (rsp_load) begin
               state_in = StIdle;
            end
         end
         default: state_in = StIdle;
      endcase
   end

   // Response register: loaded from the core, cleared when taken.
   always_comb begin
      rsp_status_in = rsp_status_ff;
      rsp_sample_in = rsp_sample_ff;
      rsp_valid_in  = rsp_valid_ff;
      if (rsp_load) begin
         rsp_status_in = res_status_ff;
         rsp_sample_in = res_sample_ff;
         rsp_valid_in  = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StIdle;
         rsp_valid_ff <= 1'b0;
         ratio_ff     <= RatioReset;
         gain_ff      <= GainReset;
         length_ff    <= LengthReset;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         ratio_ff     <= ratio_in;
         gain_ff      <= gain_in;
         length_ff    <= length_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      mix_ff        <= mix_in;
      len_ff        <= len_in;
      pos_ff        <= pos_in;
      frac_ff       <= frac_in;
      hi_addr_ff    <= hi_addr_in;
      prod_a_ff     <= prod_a_in;
      prod_b_ff     <= prod_b_in;
      a_ff          <= a_in;
      b_ff          <= b_in;
      iprod_ff      <= iprod_in;
      res_status_ff <= res_status_in;
      res_sample_ff <= res_sample_in;
      rsp_status_ff <= rsp_status_in;
      rsp_sample_ff <= rsp_sample_in;
   end

`ifndef SYNTHESIS
   // Buffer writes happen only while no read sequence is running.
   a_write_idle: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> state_ff == StIdle)
      else $error("sample RAM written outside idle");

   // Both neighbor addresses stay inside the valid buffer length.
   a_addr_clamped: assert property (@(posedge clock) disable iff (reset)
      (state_ff == StAddr && !range_err) |-> (lo_clamp < len_ff && hi_clamp < len_ff))
      else $error("neighbor address beyond buffer length");

   // A finished result is held while the response register is still occupied.
   a_result_held: assert property (@(posedge clock) disable iff (reset)
      (state_ff == StDone && rsp_valid_ff && !rsp_if.ready) |=>
      (state_ff == StDone && $stable(res_sample_ff)))
      else $error("finished result lost under stall");

   // The mix step always produces a valid-sample result.
   a_mix_status: assert property (@(posedge clock) disable iff (reset)
      (state_ff == StMix) |=> (state_ff == StDone && res_status_ff == StatusValid))
      else $error("mix step did not produce a valid sample");

   // Loading the response register frees the core and presents the response.
   a_load_response: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> (rsp_valid_ff && state_ff == StIdle))
      else $error("response load did not complete");
`endif

endmodule
